@@ hdl/sampson_error_unit_assert.svh @@
// assertion macros for the sampson error unit
// expects signals named clock and reset in the including module
`ifndef SAMPSON_ERROR_UNIT_ASSERT_SVH
`define SAMPSON_ERROR_UNIT_ASSERT_SVH

// same-cycle implication
`define SEU_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sampson error unit check failed");

// next-cycle implication
`define SEU_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sampson error unit check failed");

`endif

@@ hdl/seu_pkg.sv @@
// package for the sampson error unit: widths, register indexes, constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package seu_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int COEF_WIDTH_DEF  = 32;
   localparam int COORD_FRAC      = 4;
   localparam int NUM_SHIFT       = 8;
   localparam int ERR_WIDTH       = 32;
   localparam int DIV_STEPS       = ERR_WIDTH;
   localparam int CSR_IDX_WIDTH   = 3;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_HALF        = 32;

   localparam logic [ERR_WIDTH-1:0] ERR_MAX = '1;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_PAIR_A = 3'd0,
      CSR_PAIR_B = 3'd1,
      CSR_PAIR_C = 3'd2,
      CSR_PAIR_D = 3'd3,
      CSR_LAST   = 3'd4
   } csr_index_type;

endpackage

`default_nettype wire

@@ hdl/seu_req_if.sv @@
// point correspondence channel of the sampson error unit
// depends on seu_pkg
`timescale 1ns / 1ps
`default_nettype none

interface seu_req_if #(
   parameter int COORD_WIDTH = seu_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] first_x;
   logic signed [COORD_WIDTH-1:0] first_y;
   logic signed [COORD_WIDTH-1:0] second_x;
   logic signed [COORD_WIDTH-1:0] second_y;

   modport source (output valid, first_x, first_y, second_x, second_y, input ready);
   modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

`default_nettype wire

@@ hdl/seu_rsp_if.sv @@
// error result channel of the sampson error unit
// depends on seu_pkg
`timescale 1ns / 1ps
`default_nettype none

interface seu_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [seu_pkg::ERR_WIDTH-1:0]  sampson_err;
   logic                           zero_denominator;

   modport source (output valid, sampson_err, zero_denominator, input ready);
   modport sink   (input valid, sampson_err, zero_denominator, output ready);
endinterface

`default_nettype wire

@@ hdl/seu_csr_if.sv @@
// register write channel of the sampson error unit
// depends on seu_pkg
`timescale 1ns / 1ps
`default_nettype none

interface seu_csr_if;
   logic                                valid;
   logic                                ready;
   logic [seu_pkg::CSR_IDX_WIDTH-1:0]   index;
   logic [seu_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/sampson_error_unit.sv @@
// sampson error unit top level: pipelined error datapath and output skid
// depends on seu_pkg, seu_req_if, seu_rsp_if, seu_csr_if, sampson_error_unit_assert.svh
//
//   channel   dir   handshake     payload
//   req_ch    in    valid/ready   first_x, first_y, second_x, second_y
//   rsp_ch    out   valid/ready   sampson_err, zero_denominator
//   csr_ch    in    valid/ready   index, data (always ready)
//
// one correspondence per cycle while the skid stage is empty; a result passes through
// seven arithmetic stages, the overflow compare, 32 one-bit divide stages and the
// output register before it can transfer
// synchronous active-high reset clears valid bits and the matrix registers
// a full skid stage freezes the whole pipeline and drops req_ch.ready
`timescale 1ns / 1ps
`default_nettype none
`include "sampson_error_unit_assert.svh"

module sampson_error_unit #(
   parameter int COORD_WIDTH = seu_pkg::COORD_WIDTH_DEF,
   parameter int COEF_WIDTH  = seu_pkg::COEF_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   seu_req_if.sink    req_ch,
   seu_rsp_if.source  rsp_ch,
   seu_csr_if.sink    csr_ch
);
   import seu_pkg::*;

   localparam int W    = COORD_WIDTH;
   localparam int C    = COEF_WIDTH;
   localparam int PW   = W + C;            // coefficient times coordinate
   localparam int LW   = W + C + 1;        // epipolar line terms
   localparam int MW   = LW - 1;           // magnitude of a line term
   localparam int H    = (MW + 1) / 2;     // low split of a line term
   localparam int HI   = MW - H;
   localparam int HHW  = 2 * HI;
   localparam int LLW  = 2 * H;
   localparam int SQW  = 2 * MW;
   localparam int D    = SQW + 2;          // gradient sum
   localparam int RPW  = W + LW;           // coordinate times line term
   localparam int RW   = RPW + 1;          // residual
   localparam int RM   = RPW;              // magnitude of the residual
   localparam int HR   = (RM + 1) / 2;
   localparam int RHI  = RM - HR;
   localparam int RHHW = 2 * RHI;
   localparam int RLLW = 2 * HR;
   localparam int R2W  = 2 * RM;
   localparam int NW   = R2W + NUM_SHIFT;  // scaled numerator
   localparam int NT   = 4;                // squared terms: cx, cy, lx, ly
   localparam int NP   = 10;               // products of stage one

   // ---------------------------------------------------------------
   // matrix registers; the user must write them only while idle, the block does not enforce it
   // ---------------------------------------------------------------
   logic signed [C-1:0] f_ff [0:8];

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) f_ff[i] <= '0;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_PAIR_A: begin
               f_ff[0] <= csr_ch.data[C-1:0];
               f_ff[1] <= csr_ch.data[CSR_HALF+C-1:CSR_HALF];
            end
            CSR_PAIR_B: begin
               f_ff[2] <= csr_ch.data[C-1:0];
               f_ff[3] <= csr_ch.data[CSR_HALF+C-1:CSR_HALF];
            end
            CSR_PAIR_C: begin
               f_ff[4] <= csr_ch.data[C-1:0];
               f_ff[5] <= csr_ch.data[CSR_HALF+C-1:CSR_HALF];
            end
            CSR_PAIR_D: begin
               f_ff[6] <= csr_ch.data[C-1:0];
               f_ff[7] <= csr_ch.data[CSR_HALF+C-1:CSR_HALF];
            end
            CSR_LAST: begin
               f_ff[8] <= csr_ch.data[C-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // pipeline control: everything moves unless the skid stage is full
   // ---------------------------------------------------------------
   logic       en;
   logic       skid_vld_ff;
   logic [1:7] vld_ff;

   assign en           = !skid_vld_ff;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {req_ch.valid, vld_ff[1:6]};
      end
   end

   // stage 1: the ten coefficient products
   logic signed [PW-1:0] mp_ff [0:NP-1];
   logic signed [W-1:0]  x1_s1_ff, y1_s1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mp_ff[0] <= PW'(f_ff[0]) * PW'(req_ch.second_x);
         mp_ff[1] <= PW'(f_ff[3]) * PW'(req_ch.second_y);
         mp_ff[2] <= PW'(f_ff[1]) * PW'(req_ch.second_x);
         mp_ff[3] <= PW'(f_ff[4]) * PW'(req_ch.second_y);
         mp_ff[4] <= PW'(f_ff[2]) * PW'(req_ch.second_x);
         mp_ff[5] <= PW'(f_ff[5]) * PW'(req_ch.second_y);
         mp_ff[6] <= PW'(f_ff[0]) * PW'(req_ch.first_x);
         mp_ff[7] <= PW'(f_ff[1]) * PW'(req_ch.first_y);
         mp_ff[8] <= PW'(f_ff[3]) * PW'(req_ch.first_x);
         mp_ff[9] <= PW'(f_ff[4]) * PW'(req_ch.first_y);
         x1_s1_ff <= req_ch.first_x;
         y1_s1_ff <= req_ch.first_y;
      end
   end

   // stage 2: line terms cx, cy, lx, ly and cw
   logic signed [LW-1:0] lin_ff [0:NT-1];
   logic signed [LW-1:0] cw_s2_ff;
   logic signed [W-1:0]  x1_s2_ff, y1_s2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         lin_ff[0] <= LW'(mp_ff[0]) + LW'(mp_ff[1]) + (LW'(f_ff[6]) <<< COORD_FRAC);
         lin_ff[1] <= LW'(mp_ff[2]) + LW'(mp_ff[3]) + (LW'(f_ff[7]) <<< COORD_FRAC);
         lin_ff[2] <= LW'(mp_ff[6]) + LW'(mp_ff[7]) + (LW'(f_ff[2]) <<< COORD_FRAC);
         lin_ff[3] <= LW'(mp_ff[8]) + LW'(mp_ff[9]) + (LW'(f_ff[5]) <<< COORD_FRAC);
         cw_s2_ff  <= LW'(mp_ff[4]) + LW'(mp_ff[5]) + (LW'(f_ff[8]) <<< COORD_FRAC);
         x1_s2_ff  <= x1_s1_ff;
         y1_s2_ff  <= y1_s1_ff;
      end
   end

   // stage 3: residual products and line term magnitudes
   logic signed [RPW-1:0] rp0_ff, rp1_ff;
   logic signed [LW-1:0]  cw_s3_ff;
   logic [MW-1:0]         mag_ff [0:NT-1];

   always_ff @(posedge clock) begin
      if (en) begin
         rp0_ff   <= RPW'(x1_s2_ff) * RPW'(lin_ff[0]);
         rp1_ff   <= RPW'(y1_s2_ff) * RPW'(lin_ff[1]);
         cw_s3_ff <= cw_s2_ff;
         for (int i = 0; i < NT; i++) begin
            mag_ff[i] <= lin_ff[i][LW-1] ? MW'(-lin_ff[i]) : MW'(lin_ff[i]);
         end
      end
   end

   // stage 4: residual sum and split partial squares of the line terms
   logic signed [RW-1:0] r_s4_ff;
   logic [HHW-1:0]       hh_ff [0:NT-1];
   logic [MW-1:0]        hl_ff [0:NT-1];
   logic [LLW-1:0]       ll_ff [0:NT-1];

   always_ff @(posedge clock) begin
      if (en) begin
         r_s4_ff <= RW'(rp0_ff) + RW'(rp1_ff) + (RW'(cw_s3_ff) <<< COORD_FRAC);
         for (int i = 0; i < NT; i++) begin
            hh_ff[i] <= HHW'(mag_ff[i][MW-1:H]) * HHW'(mag_ff[i][MW-1:H]);
            hl_ff[i] <= MW'(mag_ff[i][MW-1:H]) * MW'(mag_ff[i][H-1:0]);
            ll_ff[i] <= LLW'(mag_ff[i][H-1:0]) * LLW'(mag_ff[i][H-1:0]);
         end
      end
   end

   // stage 5: assembled squares and residual magnitude
   logic [SQW-1:0] sq_ff [0:NT-1];
   logic [RM-1:0]  rmag_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NT; i++) begin
            sq_ff[i] <= (SQW'(hh_ff[i]) << (2 * H)) + (SQW'(hl_ff[i]) << (H + 1))
                      + SQW'(ll_ff[i]);
         end
         rmag_ff <= r_s4_ff[RW-1] ? RM'(-r_s4_ff) : RM'(r_s4_ff);
      end
   end

   // stage 6: gradient sum and split partial squares of the residual
   logic [D-1:0]    den_s6_ff;
   logic [RHHW-1:0] rhh_ff;
   logic [RM-1:0]   rhl_ff;
   logic [RLLW-1:0] rll_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         den_s6_ff <= D'(sq_ff[0]) + D'(sq_ff[1]) + D'(sq_ff[2]) + D'(sq_ff[3]);
         rhh_ff    <= RHHW'(rmag_ff[RM-1:HR]) * RHHW'(rmag_ff[RM-1:HR]);
         rhl_ff    <= RM'(rmag_ff[RM-1:HR]) * RM'(rmag_ff[HR-1:0]);
         rll_ff    <= RLLW'(rmag_ff[HR-1:0]) * RLLW'(rmag_ff[HR-1:0]);
      end
   end

   // stage 7: scaled numerator, zero check
   logic [R2W-1:0] r2_in;
   logic [NW-1:0]  num_s7_ff;
   logic [D-1:0]   den_s7_ff;
   logic           zero_s7_ff;

   assign r2_in = (R2W'(rhh_ff) << (2 * HR)) + (R2W'(rhl_ff) << (HR + 1)) + R2W'(rll_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         num_s7_ff  <= NW'(r2_in) << NUM_SHIFT;
         den_s7_ff  <= den_s6_ff;
         zero_s7_ff <= (den_s6_ff == '0);
      end
   end

   // ---------------------------------------------------------------
   // overflow compare (slot 0) then one quotient bit per slot, msb first
   // ---------------------------------------------------------------
   logic [NW-1:0]        dv_rem_ff  [0:DIV_STEPS];
   logic [D-1:0]         dv_den_ff  [0:DIV_STEPS];
   logic [ERR_WIDTH-1:0] dv_q_ff    [0:DIV_STEPS];
   logic                 dv_sat_ff  [0:DIV_STEPS];
   logic                 dv_zero_ff [0:DIV_STEPS];
   logic [0:DIV_STEPS]   dv_vld_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dv_rem_ff[0]  <= num_s7_ff;
         dv_den_ff[0]  <= den_s7_ff;
         dv_q_ff[0]    <= '0;
         dv_sat_ff[0]  <= (num_s7_ff >= (NW'(den_s7_ff) << ERR_WIDTH));
         dv_zero_ff[0] <= zero_s7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff <= '0;
      end else if (en) begin
         dv_vld_ff <= {vld_ff[7], dv_vld_ff[0:DIV_STEPS-1]};
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int K = DIV_STEPS - 1 - j;
      logic [NW-1:0] dsh;
      logic          take;

      assign dsh  = NW'(dv_den_ff[j]) << K;
      assign take = (dv_rem_ff[j] >= dsh);

      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[j+1]  <= take ? (dv_rem_ff[j] - dsh) : dv_rem_ff[j];
            dv_den_ff[j+1]  <= dv_den_ff[j];
            dv_q_ff[j+1]    <= {dv_q_ff[j][ERR_WIDTH-2:0], take};
            dv_sat_ff[j+1]  <= dv_sat_ff[j];
            dv_zero_ff[j+1] <= dv_zero_ff[j];
         end
      end
   end

   // ---------------------------------------------------------------
   // output register with skid stage
   // ---------------------------------------------------------------
   logic                 last_vld;
   logic [ERR_WIDTH-1:0] last_err;
   logic                 last_zero;
   logic                 out_vld_ff, out_vld_in, skid_vld_in;
   logic                 out_take, out_load, out_from_skid, skid_load;
   logic [ERR_WIDTH-1:0] out_err_ff, skid_err_ff;
   logic                 out_zero_ff, skid_zero_ff;

   assign last_vld  = dv_vld_ff[DIV_STEPS];
   assign last_err  = dv_sat_ff[DIV_STEPS] ? ERR_MAX : dv_q_ff[DIV_STEPS];
   assign last_zero = dv_zero_ff[DIV_STEPS];
   assign out_take  = out_vld_ff && rsp_ch.ready;

   always_comb begin
      out_vld_in    = out_vld_ff;
      skid_vld_in   = skid_vld_ff;
      out_load      = 1'b0;
      out_from_skid = 1'b0;
      skid_load     = 1'b0;
      if (skid_vld_ff) begin
         // pipeline frozen, drain the skid entry first
         if (out_take) begin
            out_load      = 1'b1;
            out_from_skid = 1'b1;
            skid_vld_in   = 1'b0;
         end
      end else if (last_vld) begin
         if (!out_vld_ff || out_take) begin
            out_load   = 1'b1;
            out_vld_in = 1'b1;
         end else begin
            skid_load   = 1'b1;
            skid_vld_in = 1'b1;
         end
      end else if (out_take) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_err_ff  <= out_from_skid ? skid_err_ff : last_err;
         out_zero_ff <= out_from_skid ? skid_zero_ff : last_zero;
      end
      if (skid_load) begin
         skid_err_ff  <= last_err;
         skid_zero_ff <= last_zero;
      end
   end

   assign rsp_ch.valid            = out_vld_ff;
   assign rsp_ch.sampson_err      = out_err_ff;
   assign rsp_ch.zero_denominator = out_zero_ff;

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   `SEU_ASSERT_IMP(a_skid_behind_out, skid_vld_ff, out_vld_ff)
   `SEU_ASSERT_IMP(a_zero_gives_max, out_vld_ff && out_zero_ff, out_err_ff == ERR_MAX)
   `SEU_ASSERT_IMP(a_zero_implies_sat, dv_vld_ff[0] && dv_zero_ff[0], dv_sat_ff[0])
   `SEU_ASSERT_NXT(a_freeze_holds_tail, skid_vld_ff && !out_take,
                   $stable(dv_vld_ff[DIV_STEPS]))

endmodule

`default_nettype wire
